>>> rtl/core/qath_pkg.sv
// Shared types, constants and tables for the quaternion inverse hyperbolic tangent unit.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package qath_pkg;

    localparam int DATA_WIDTH    = 16;
    localparam int FRAC_BITS     = 12;
    localparam int CORDIC_STAGES = 16;
    localparam int LOG_FRAC      = 24;
    localparam int SQRT_STAGES   = 32;
    localparam int DIV_STAGES    = 17;

    // Angles in Q30 radians, ln 2 in Q30
    localparam logic [32:0] PI_Q30      = 33'd3373259426;
    localparam logic [32:0] PI_HALF_Q30 = 33'd1686629713;
    localparam logic [29:0] LN2_Q30     = 30'd744261118;

    // Saturation values
    localparam logic [15:0] SAT_MAX = 16'h7fff;
    localparam logic [15:0] SAT_MIN = 16'h8000;

    // Log2 cell state: mantissa Q1.30, integer part, fraction bits so far
    typedef struct packed {
        logic [30:0] m;
        logic [5:0]  e;
        logic [23:0] f;
    } log_t;

    // Square root cell state: remainder and partial root
    typedef struct packed {
        logic [63:0] v;
        logic [63:0] r;
    } sqrt_t;

    // CORDIC vectoring cell state
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] ang;
        logic               hold;
    } cordic_t;

    // Divider cell state for one vector lane
    typedef struct packed {
        logic [48:0] rem;
        logic [34:0] den;
        logic [16:0] q;
        logic        ovf;
    } div_t;

    // Per-item side information carried alongside the datapath
    typedef struct packed {
        logic [2:0][15:0] cabs;
        logic [2:0]       cneg;
        logic             a_pos;
        logic             pole;
        logic             bzero;
    } side_t;

    // atan(2^-i) in Q30 radians, rounded to nearest
    function automatic logic [29:0] atan_q30(input logic [3:0] i);
        logic [29:0] v;
        unique case (i)
            4'd0:  v = 30'd843314857;
            4'd1:  v = 30'd497837829;
            4'd2:  v = 30'd263043837;
            4'd3:  v = 30'd133525159;
            4'd4:  v = 30'd67021687;
            4'd5:  v = 30'd33543516;
            4'd6:  v = 30'd16775851;
            4'd7:  v = 30'd8388437;
            4'd8:  v = 30'd4194283;
            4'd9:  v = 30'd2097149;
            4'd10: v = 30'd1048576;
            4'd11: v = 30'd524288;
            4'd12: v = 30'd262144;
            4'd13: v = 30'd131072;
            4'd14: v = 30'd65536;
            default: v = 30'd32768;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/qath_log_cell.sv
// One squaring step of the fractional log2: produces one fraction bit.
// Depends on qath_pkg (log_t).
module qath_log_cell #(
    parameter int BIT = 0
) (
    input  logic           clk,
    input  qath_pkg::log_t din,
    output qath_pkg::log_t dout
);

    logic [61:0]    sq;
    logic [31:0]    sq_hi;
    qath_pkg::log_t stage_next;
    qath_pkg::log_t stage_reg;

    // square the mantissa, renormalise into [1,2)
    always_comb
    begin
        sq         = 62'(din.m) * 62'(din.m);
        sq_hi      = sq[61:30];
        stage_next = din;
        if (sq_hi[31])
        begin
            stage_next.m      = sq_hi[31:1];
            stage_next.f[BIT] = 1'b1;
        end
        else
        begin
            stage_next.m = sq_hi[30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign dout = stage_reg;

endmodule

>>> rtl/core/qath_sqrt_cell.sv
// One digit step of the integer square root (one root bit per cell).
// Depends on qath_pkg (sqrt_t).
module qath_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic            clk,
    input  qath_pkg::sqrt_t din,
    output qath_pkg::sqrt_t dout
);

    localparam logic [63:0] BIT_VAL = 64'd1 << (62 - 2 * STEP);

    logic [63:0]     trial;
    qath_pkg::sqrt_t stage_next;
    qath_pkg::sqrt_t stage_reg;

    // trial subtract of root plus current bit
    always_comb
    begin
        trial = din.r + BIT_VAL;
        if (din.v >= trial)
        begin
            stage_next.v = din.v - trial;
            stage_next.r = (din.r >> 1) + BIT_VAL;
        end
        else
        begin
            stage_next.v = din.v;
            stage_next.r = din.r >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign dout = stage_reg;

endmodule

>>> rtl/core/qath_cordic_cell.sv
// One CORDIC vectoring micro-rotation with its arctangent accumulation.
// Depends on qath_pkg (cordic_t, atan_q30).
module qath_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic              clk,
    input  qath_pkg::cordic_t din,
    output qath_pkg::cordic_t dout
);

    logic signed [33:0] xin;
    logic signed [33:0] yin;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] at;
    qath_pkg::cordic_t  stage_next;
    qath_pkg::cordic_t  stage_reg;

    // rotate towards the x axis; held items pass unchanged
    always_comb
    begin
        xin        = din.x;
        yin        = din.y;
        dx         = yin >>> STEP;
        dy         = xin >>> STEP;
        at         = $signed({4'b0, qath_pkg::atan_q30(4'(STEP))});
        stage_next = din;
        if (!din.hold)
        begin
            if (yin > 34'sd0)
            begin
                stage_next.x   = xin + dx;
                stage_next.y   = yin - dy;
                stage_next.ang = din.ang + at;
            end
            else
            begin
                stage_next.x   = xin - dx;
                stage_next.y   = yin + dy;
                stage_next.ang = din.ang - at;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign dout = stage_reg;

endmodule

>>> rtl/core/qath_div_cell.sv
// One restoring division step for a vector lane: one quotient bit per cell.
// Depends on qath_pkg (div_t).
module qath_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic           clk,
    input  qath_pkg::div_t din,
    output qath_pkg::div_t dout
);

    logic [51:0]    dsh;
    qath_pkg::div_t stage_next;
    qath_pkg::div_t stage_reg;

    // compare against the shifted divisor, subtract when it fits
    always_comb
    begin
        dsh        = 52'(din.den) << SHIFT;
        stage_next = din;
        if (52'(din.rem) >= dsh)
        begin
            stage_next.rem      = din.rem - dsh[48:0];
            stage_next.q[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign dout = stage_reg;

endmodule

>>> rtl/core/quaternion_inverse_hyperbolic_tangent_unit.sv
// Top level of the quaternion inverse hyperbolic tangent unit (Q3.12 in, Q3.12 out).
// Depends on qath_pkg and the cell modules qath_log_cell, qath_sqrt_cell,
// qath_cordic_cell and qath_div_cell.
//
//  channel  | signals                                     | transfer
//  ---------+---------------------------------------------+--------------------------
//  command  | start, busy, scalar_part, vec_x/y/z         | edge with start && !busy
//  result   | done, out_scalar, out_x/y/z,                | edge ending the done cycle
//           | pole_or_saturated                           |
//
// One quaternion is taken every cycle; busy stays low.
// From the command transfer to the done cycle, an item passes through the chain of 32 square root
// cells, 16 CORDIC cells and 17 divider cells in series.
// Reset clears only the valid pipeline; results still in flight at reset are dropped.
// The result side has no backpressure, so nothing in the chain ever stalls.
module quaternion_inverse_hyperbolic_tangent_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] scalar_part,
    input  logic signed [15:0] vec_x,
    input  logic signed [15:0] vec_y,
    input  logic signed [15:0] vec_z,
    output logic               done,
    output logic signed [15:0] out_scalar,
    output logic signed [15:0] out_x,
    output logic signed [15:0] out_y,
    output logic signed [15:0] out_z,
    output logic               pole_or_saturated
);

    localparam int LAT       = 73;
    localparam int X0_DEPTH  = qath_pkg::SQRT_STAGES;
    localparam int BQ_DEPTH  = 18;
    localparam int SIDE_DEPTH = 69;
    localparam int H_DEPTH   = 19;
    localparam int RE_DEPTH  = 42;

    typedef struct packed {
        logic [15:0] re;
        logic        flag;
    } re_t;

    // leading one position of a 33-bit word
    function automatic logic [5:0] lead_pos(input logic [32:0] v);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 33; i++)
        begin
            if (v[i])
            begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

    // integer part and Q1.30 mantissa of log2 of a word
    function automatic qath_pkg::log_t log_init(input logic [32:0] v);
        qath_pkg::log_t s;
        logic [5:0]     lp;
        logic [32:0]    t;
        lp  = lead_pos(v);
        s.f = '0;
        if (v == 33'd0)
        begin
            s.e = 6'd0;
            s.m = 31'h4000_0000;
        end
        else
        begin
            s.e = lp;
            if (lp >= 6'd30)
            begin
                t = v >> (lp - 6'd30);
            end
            else
            begin
                t = v << (6'd30 - lp);
            end
            s.m = t[30:0];
        end
        return s;
    endfunction

    // clamp a magnitude with sign into the signed output range
    function automatic re_t clamp_sm(input logic [16:0] mag, input logic neg);
        re_t o;
        logic [16:0] n;
        n = 17'(-mag);
        o.flag = 1'b0;
        if (neg)
        begin
            if (mag > 17'd32768)
            begin
                o.re   = qath_pkg::SAT_MIN;
                o.flag = 1'b1;
            end
            else
            begin
                o.re = n[15:0];
            end
        end
        else
        begin
            if (mag > 17'd32767)
            begin
                o.re   = qath_pkg::SAT_MAX;
                o.flag = 1'b1;
            end
            else
            begin
                o.re = mag[15:0];
            end
        end
        return o;
    endfunction

    assign busy = 1'b0;

    // ---------------- stage 1: magnitudes and squares ----------------
    logic [15:0]        aabs;
    logic signed [17:0] ups;
    logic signed [17:0] ums;
    logic [16:0]        upm;
    logic [16:0]        umm;
    logic [2:0][15:0]   cabs_c;
    logic [2:0]         cneg_c;
    logic [2:0][15:0]   vin;

    always_comb
    begin
        vin[0] = vec_x;
        vin[1] = vec_y;
        vin[2] = vec_z;
        aabs   = scalar_part[15] ? 16'(-scalar_part) : scalar_part;
        ups    = 18'(scalar_part) + 18'sd4096;
        ums    = 18'sd4096 - 18'(scalar_part);
        upm    = ups[17] ? 17'(-ups) : ups[16:0];
        umm    = ums[17] ? 17'(-ums) : ums[16:0];
        for (int k = 0; k < 3; k++)
        begin
            cneg_c[k] = vin[k][15];
            cabs_c[k] = vin[k][15] ? 16'(-vin[k]) : vin[k];
        end
    end

    logic [30:0]      a2_reg;
    logic [2:0][30:0] c2_reg;
    logic [30:0]      up2_reg;
    logic [30:0]      um2_reg;
    logic [2:0][15:0] cabs1_reg;
    logic [2:0]       cneg1_reg;
    logic             apos1_reg;
    logic             apm1_reg;

    always_ff @(posedge clk)
    begin
        a2_reg  <= 31'(32'(aabs) * 32'(aabs));
        up2_reg <= 31'(34'(upm) * 34'(upm));
        um2_reg <= 31'(34'(umm) * 34'(umm));
        for (int k = 0; k < 3; k++)
        begin
            c2_reg[k] <= 31'(32'(cabs_c[k]) * 32'(cabs_c[k]));
        end
        cabs1_reg <= cabs_c;
        cneg1_reg <= cneg_c;
        apos1_reg <= ~scalar_part[15];
        apm1_reg  <= (scalar_part == 16'sd4096) || (scalar_part == -16'sd4096);
    end

    // ---------------- stage 2: norms, P, M and angle x operand ----------------
    logic [31:0]        b2_c;
    logic [30:0]        tq_c;
    logic [31:0]        b2_reg;
    logic [32:0]        p_reg;
    logic [32:0]        m_reg;
    logic signed [32:0] x0_reg;
    qath_pkg::side_t    side2_reg;

    always_comb
    begin
        b2_c = 32'(c2_reg[0]) + 32'(c2_reg[1]) + 32'(c2_reg[2]);
        tq_c = 31'(a2_reg >> 2) + 31'(b2_c >> 2);
    end

    always_ff @(posedge clk)
    begin
        b2_reg          <= b2_c;
        p_reg           <= 33'(up2_reg) + 33'(b2_c);
        m_reg           <= 33'(um2_reg) + 33'(b2_c);
        x0_reg          <= 33'sd4194304 - $signed({2'b0, tq_c});
        side2_reg.cabs  <= cabs1_reg;
        side2_reg.cneg  <= cneg1_reg;
        side2_reg.a_pos <= apos1_reg;
        side2_reg.pole  <= (b2_c == 32'd0) && apm1_reg;
        side2_reg.bzero <= (b2_c == 32'd0);
    end

    // ---------------- stage 3: chain entry ----------------
    qath_pkg::log_t     logp3_reg;
    qath_pkg::log_t     logm3_reg;
    qath_pkg::sqrt_t    sqrt3_reg;
    logic signed [32:0] x03_reg;
    qath_pkg::side_t    side3_reg;

    always_ff @(posedge clk)
    begin
        logp3_reg   <= log_init(p_reg);
        logm3_reg   <= log_init(m_reg);
        sqrt3_reg.v <= {b2_reg, 32'd0};
        sqrt3_reg.r <= 64'd0;
        x03_reg     <= x0_reg;
        side3_reg   <= side2_reg;
    end

    // ---------------- log2 chains for P and M ----------------
    qath_pkg::log_t logp_chain [qath_pkg::LOG_FRAC+1];
    qath_pkg::log_t logm_chain [qath_pkg::LOG_FRAC+1];

    assign logp_chain[0] = logp3_reg;
    assign logm_chain[0] = logm3_reg;

    for (genvar g = 0; g < qath_pkg::LOG_FRAC; g++)
    begin : g_log
        qath_log_cell #(.BIT(qath_pkg::LOG_FRAC - 1 - g)) u_logp (
            .clk  (clk),
            .din  (logp_chain[g]),
            .dout (logp_chain[g+1])
        );
        qath_log_cell #(.BIT(qath_pkg::LOG_FRAC - 1 - g)) u_logm (
            .clk  (clk),
            .din  (logm_chain[g]),
            .dout (logm_chain[g+1])
        );
    end

    // ---------------- real part: difference, scale by ln2/4, round ----------------
    logic [29:0]        logp_c;
    logic [29:0]        logm_c;
    logic signed [30:0] d_c;
    logic [29:0]        dabs_reg;
    logic               dneg_reg;
    logic [59:0]        prod_reg;
    logic               dneg2_reg;
    logic [60:0]        prod_rnd;
    re_t                re_reg;
    re_t                re_dly_reg [RE_DEPTH];

    always_comb
    begin
        logp_c   = {logp_chain[qath_pkg::LOG_FRAC].e, logp_chain[qath_pkg::LOG_FRAC].f};
        logm_c   = {logm_chain[qath_pkg::LOG_FRAC].e, logm_chain[qath_pkg::LOG_FRAC].f};
        d_c      = $signed({1'b0, logp_c}) - $signed({1'b0, logm_c});
        prod_rnd = 61'(prod_reg) + (61'd1 << 43);
    end

    always_ff @(posedge clk)
    begin
        dneg_reg  <= d_c[30];
        dabs_reg  <= d_c[30] ? 30'(-d_c) : d_c[29:0];
        prod_reg  <= 60'(dabs_reg) * 60'(qath_pkg::LN2_Q30);
        dneg2_reg <= dneg_reg;
        re_reg    <= clamp_sm(prod_rnd[60:44], dneg2_reg);
        re_dly_reg[0] <= re_reg;
        for (int i = 1; i < RE_DEPTH; i++)
        begin
            re_dly_reg[i] <= re_dly_reg[i-1];
        end
    end

    // ---------------- square root chain for the vector norm ----------------
    qath_pkg::sqrt_t sqrt_chain [qath_pkg::SQRT_STAGES+1];

    assign sqrt_chain[0] = sqrt3_reg;

    for (genvar g = 0; g < qath_pkg::SQRT_STAGES; g++)
    begin : g_sqrt
        qath_sqrt_cell #(.STEP(g)) u_sqrt (
            .clk  (clk),
            .din  (sqrt_chain[g]),
            .dout (sqrt_chain[g+1])
        );
    end

    // side information and angle operand follow the chains
    logic signed [32:0] x0_dly_reg   [X0_DEPTH];
    qath_pkg::side_t    side_dly_reg [SIDE_DEPTH];

    always_ff @(posedge clk)
    begin
        x0_dly_reg[0]   <= x03_reg;
        side_dly_reg[0] <= side3_reg;
        for (int i = 1; i < X0_DEPTH; i++)
        begin
            x0_dly_reg[i] <= x0_dly_reg[i-1];
        end
        for (int i = 1; i < SIDE_DEPTH; i++)
        begin
            side_dly_reg[i] <= side_dly_reg[i-1];
        end
    end

    // ---------------- angle operand normalisation ----------------
    logic [31:0]        bq_c;
    logic [26:0]        yv_c;
    logic signed [32:0] x0n_c;
    logic [30:0]        ux_c;
    logic [30:0]        uy_c;
    logic [30:0]        or_c;
    logic [30:0]        uxn_c;
    logic [30:0]        uyn_c;
    logic [5:0]         nlead_c;
    logic [4:0]         lsh_c;
    logic               hold_c;
    qath_pkg::cordic_t  cord_next;
    qath_pkg::cordic_t  cord0_reg;
    logic [32:0]        x0neg_c;

    always_comb
    begin
        bq_c    = sqrt_chain[qath_pkg::SQRT_STAGES].r[31:0];
        yv_c    = bq_c[31:5];
        x0n_c   = x0_dly_reg[X0_DEPTH-1];
        x0neg_c = 33'(-x0n_c);
        ux_c    = x0n_c[32] ? x0neg_c[30:0] : x0n_c[30:0];
        uy_c    = 31'(yv_c);
        or_c    = ux_c | uy_c;
        nlead_c = lead_pos({2'b0, or_c});
        lsh_c   = 5'(6'd29 - nlead_c);
        if (or_c[30])
        begin
            uxn_c = ux_c >> 1;
            uyn_c = uy_c >> 1;
        end
        else
        begin
            uxn_c = ux_c << lsh_c;
            uyn_c = uy_c << lsh_c;
        end
        hold_c = (yv_c == 27'd0) || (uyn_c == 31'd0);
        cord_next.hold = hold_c;
        if (hold_c)
        begin
            cord_next.x   = '0;
            cord_next.y   = '0;
            cord_next.ang = x0n_c[32] ? $signed({1'b0, qath_pkg::PI_Q30}) : 34'sd0;
        end
        else if (x0n_c[32])
        begin
            cord_next.x   = $signed({3'b0, uyn_c});
            cord_next.y   = $signed({3'b0, uxn_c});
            cord_next.ang = $signed({1'b0, qath_pkg::PI_HALF_Q30});
        end
        else
        begin
            cord_next.x   = $signed({3'b0, uxn_c});
            cord_next.y   = $signed({3'b0, uyn_c});
            cord_next.ang = 34'sd0;
        end
    end

    logic [31:0] bq_dly_reg [BQ_DEPTH];

    always_ff @(posedge clk)
    begin
        cord0_reg     <= cord_next;
        bq_dly_reg[0] <= bq_c;
        for (int i = 1; i < BQ_DEPTH; i++)
        begin
            bq_dly_reg[i] <= bq_dly_reg[i-1];
        end
    end

    // ---------------- CORDIC chain ----------------
    qath_pkg::cordic_t cord_chain [qath_pkg::CORDIC_STAGES+1];

    assign cord_chain[0] = cord0_reg;

    for (genvar g = 0; g < qath_pkg::CORDIC_STAGES; g++)
    begin : g_cordic
        qath_cordic_cell #(.STEP(g)) u_cordic (
            .clk  (clk),
            .din  (cord_chain[g]),
            .dout (cord_chain[g+1])
        );
    end

    // ---------------- angle clamp, half angle, spread products ----------------
    logic signed [33:0] ang_c;
    logic [31:0]        angc_reg;
    logic [32:0]        h_sum;
    logic [13:0]        h_dly_reg [H_DEPTH];
    logic [2:0][47:0]   num_reg;
    logic [34:0]        den_reg;

    always_comb
    begin
        ang_c = cord_chain[qath_pkg::CORDIC_STAGES].ang;
        h_sum = 33'(angc_reg) + (33'd1 << 18);
    end

    always_ff @(posedge clk)
    begin
        if (ang_c < 34'sd0)
        begin
            angc_reg <= 32'd0;
        end
        else if (ang_c > $signed({1'b0, qath_pkg::PI_Q30}))
        begin
            angc_reg <= qath_pkg::PI_Q30[31:0];
        end
        else
        begin
            angc_reg <= ang_c[31:0];
        end
        h_dly_reg[0] <= h_sum[32:19];
        for (int i = 1; i < H_DEPTH; i++)
        begin
            h_dly_reg[i] <= h_dly_reg[i-1];
        end
        for (int k = 0; k < 3; k++)
        begin
            num_reg[k] <= 48'(side_dly_reg[49].cabs[k]) * 48'(angc_reg);
        end
        den_reg <= {bq_dly_reg[BQ_DEPTH-1], 3'b0};
    end

    // ---------------- divider entry and chains, one per lane ----------------
    qath_pkg::div_t div_chain [3][qath_pkg::DIV_STAGES+1];
    qath_pkg::div_t div0_reg  [3];
    logic [48:0]    nrnd_c    [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            nrnd_c[k] = 49'(num_reg[k]) + 49'(den_reg >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            div0_reg[k].rem <= nrnd_c[k];
            div0_reg[k].den <= den_reg;
            div0_reg[k].q   <= '0;
            div0_reg[k].ovf <= 52'(nrnd_c[k]) >= (52'(den_reg) << qath_pkg::DIV_STAGES);
        end
    end

    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        assign div_chain[l][0] = div0_reg[l];
        for (genvar g = 0; g < qath_pkg::DIV_STAGES; g++)
        begin : g_div
            qath_div_cell #(.SHIFT(qath_pkg::DIV_STAGES - 1 - g)) u_div (
                .clk  (clk),
                .din  (div_chain[l][g]),
                .dout (div_chain[l][g+1])
            );
        end
    end

    // ---------------- result assembly ----------------
    qath_pkg::side_t  side_f;
    re_t              re_f;
    re_t              lane_c [3];
    logic [15:0]      res_next [4];
    logic             flag_next;
    logic [15:0]      res_reg [4];
    logic             flag_reg;

    always_comb
    begin
        side_f = side_dly_reg[SIDE_DEPTH-1];
        re_f   = re_dly_reg[RE_DEPTH-1];
        for (int k = 0; k < 3; k++)
        begin
            if (div_chain[k][qath_pkg::DIV_STAGES].ovf)
            begin
                lane_c[k].re   = side_f.cneg[k] ? qath_pkg::SAT_MIN : qath_pkg::SAT_MAX;
                lane_c[k].flag = 1'b1;
            end
            else
            begin
                lane_c[k] = clamp_sm(div_chain[k][qath_pkg::DIV_STAGES].q, side_f.cneg[k]);
            end
        end
        if (side_f.pole)
        begin
            res_next[0] = side_f.a_pos ? qath_pkg::SAT_MAX : qath_pkg::SAT_MIN;
            res_next[1] = '0;
            res_next[2] = '0;
            res_next[3] = '0;
            flag_next   = 1'b1;
        end
        else if (side_f.bzero)
        begin
            res_next[0] = re_f.re;
            res_next[1] = 16'(h_dly_reg[H_DEPTH-1]);
            res_next[2] = '0;
            res_next[3] = '0;
            flag_next   = re_f.flag;
        end
        else
        begin
            res_next[0] = re_f.re;
            res_next[1] = lane_c[0].re;
            res_next[2] = lane_c[1].re;
            res_next[3] = lane_c[2].re;
            flag_next   = re_f.flag | lane_c[0].flag | lane_c[1].flag | lane_c[2].flag;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            res_reg[k] <= res_next[k];
        end
        flag_reg <= flag_next;
    end

    // ---------------- valid pipeline ----------------
    logic [LAT-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], start};
        end
    end

    assign done              = vld_reg[LAT-1];
    assign out_scalar        = res_reg[0];
    assign out_x             = res_reg[1];
    assign out_y             = res_reg[2];
    assign out_z             = res_reg[3];
    assign pole_or_saturated = flag_reg;

`ifndef SYNTHESIS
    // pole at +1 gives the largest scalar and the flag
    a_pole_pos: assert property (@(posedge clk) disable iff (!rst_n)
        start && (scalar_part == 16'sd4096) && (vec_x == 16'sd0) && (vec_y == 16'sd0)
        && (vec_z == 16'sd0)
        |-> ##73 done && pole_or_saturated && (out_scalar == 16'sh7fff))
        else $error("pole at +1 not saturated high");

    // pole at -1 gives the smallest scalar and the flag
    a_pole_neg: assert property (@(posedge clk) disable iff (!rst_n)
        start && (scalar_part == -16'sd4096) && (vec_x == 16'sd0) && (vec_y == 16'sd0)
        && (vec_z == 16'sd0)
        |-> ##73 done && pole_or_saturated && (out_scalar == 16'sh8000))
        else $error("pole at -1 not saturated low");

    // zero in gives zero out, unflagged
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        start && (scalar_part == 16'sd0) && (vec_x == 16'sd0) && (vec_y == 16'sd0)
        && (vec_z == 16'sd0)
        |-> ##73 done && !pole_or_saturated && (out_scalar == 16'sd0) && (out_x == 16'sd0)
        && (out_y == 16'sd0) && (out_z == 16'sd0))
        else $error("zero quaternion did not map to zero");
`endif

endmodule

>>> test/quaternion_inverse_hyperbolic_tangent_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for quaternion_inverse_hyperbolic_tangent_unit.
// Depends on qath_pkg and the unit itself; a bit-exact fixed-point predictor is held here.
module quaternion_inverse_hyperbolic_tangent_unit_tb;

    localparam int DATA_WIDTH    = qath_pkg::DATA_WIDTH;
    localparam int FRAC_BITS     = qath_pkg::FRAC_BITS;
    localparam int CORDIC_STAGES = qath_pkg::CORDIC_STAGES;

    localparam int LOGF         = 24;
    localparam longint ONE_Q    = 64'sd1 << FRAC_BITS;
    localparam longint SAT_HI   = (64'sd1 << (DATA_WIDTH - 1)) - 1;
    localparam longint SAT_LO   = -SAT_HI - 1;
    localparam longint QPI      = 64'sd3373259426;
    localparam longint QPI_HALF = 64'sd1686629713;
    localparam longint QPI_QTR  = 64'sd843314857;
    localparam longint QLN2     = 64'sd744261118;
    localparam int LATENCY      = 73;

    typedef struct packed {
        logic [15:0] s;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic        flag;
    } atanh_res_t;

    // Scoreboard: predicts atanh of each transferred quaternion and checks results in order
    class atanh_scoreboard;
        atanh_res_t pending_atanh[$];
        longint     atan_tab[CORDIC_STAGES];
        int         mismatches;
        int         checked;

        function new();
            longint acc;
            longint term;
            int ex;
            mismatches = 0;
            checked    = 0;
            // arctangent of 2^-i in Q30, by series for i > 0
            for (int i = 0; i < CORDIC_STAGES; i++)
            begin
                if (i == 0)
                begin
                    atan_tab[i] = QPI_QTR;
                end
                else
                begin
                    acc = 0;
                    for (int k = 0; k < 64; k++)
                    begin
                        ex = 60 - i * (2 * k + 1);
                        if (ex < 0)
                            break;
                        term = (64'sd1 <<< ex) / (2 * k + 1);
                        acc  = (k & 1) ? acc - term : acc + term;
                    end
                    atan_tab[i] = (acc + (64'sd1 <<< 29)) >>> 30;
                end
            end
        endfunction

        static function logic [15:0] sat16(longint v, ref bit flag);
            if (v > SAT_HI)
            begin
                v = SAT_HI;
                flag = 1;
            end
            if (v < SAT_LO)
            begin
                v = SAT_LO;
                flag = 1;
            end
            return v[15:0];
        endfunction

        static function longint unsigned mag64(longint v);
            return v < 0 ? longint'(0) - v : v;
        endfunction

        // log2 with LOGF fraction bits, by repeated squaring of a Q1.30 mantissa
        static function longint log2_q(bit carry, longint unsigned lo);
            longint unsigned m;
            longint unsigned f;
            longint unsigned t;
            int e;
            f = 0;
            if (carry)
            begin
                e = 64;
                m = (lo >> 34) | (64'd1 << 30);
            end
            else
            begin
                if (lo == 0)
                    return 0;
                e = 0;
                t = lo;
                while (t > 1)
                begin
                    t >>= 1;
                    e++;
                end
                m = e >= 30 ? lo >> (e - 30) : lo << (30 - e);
            end
            for (int k = LOGF - 1; k >= 0; k--)
            begin
                m = (m * m) >> 30;
                if (m >= (64'd1 << 31))
                begin
                    m >>= 1;
                    f |= 64'd1 << k;
                end
            end
            return (longint'(e) <<< LOGF) + longint'(f);
        endfunction

        static function longint unsigned root64(longint unsigned v);
            longint unsigned r;
            longint unsigned bv;
            r  = 0;
            bv = 64'd1 << 62;
            while (bv > v)
                bv >>= 2;
            while (bv != 0)
            begin
                if (v >= r + bv)
                begin
                    v -= r + bv;
                    r = (r >> 1) + bv;
                end
                else
                begin
                    r >>= 1;
                end
                bv >>= 2;
            end
            return r;
        endfunction

        // atan2(y0, x0) in Q30 for y0 >= 0, clamped to [0, pi]
        function longint angle_of(longint x0, longint unsigned y0);
            longint unsigned ux;
            longint unsigned uy;
            longint x;
            longint y;
            longint ang;
            longint dx;
            longint dy;
            ux = mag64(x0);
            uy = y0;
            if (uy == 0)
                return x0 < 0 ? QPI : 0;
            while ((ux | uy) >= (64'd1 << 30))
            begin
                ux >>= 1;
                uy >>= 1;
            end
            while ((ux | uy) < (64'd1 << 29))
            begin
                ux <<= 1;
                uy <<= 1;
            end
            if (uy == 0)
                return x0 < 0 ? QPI : 0;
            if (x0 < 0)
            begin
                x = longint'(uy);
                y = longint'(ux);
                ang = QPI_HALF;
            end
            else
            begin
                x = longint'(ux);
                y = longint'(uy);
                ang = 0;
            end
            for (int i = 0; i < CORDIC_STAGES; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0)
                begin
                    x += dx;
                    y -= dy;
                    ang += atan_tab[i];
                end
                else
                begin
                    x -= dx;
                    y += dy;
                    ang -= atan_tab[i];
                end
            end
            if (ang < 0)
                ang = 0;
            if (ang > QPI)
                ang = QPI;
            return ang;
        endfunction

        function atanh_res_t atanh_predict(logic signed [15:0] a16, logic signed [15:0] c16[3]);
            atanh_res_t r;
            longint a;
            longint c[3];
            longint unsigned b2, up, um, sq, plo, mlo, prod, mag, bq, tq, yv, num, den, q;
            bit pc, mc;
            bit flag;
            longint d, re, x0, ang, h;
            int e;
            e = 32 - DATA_WIDTH;
            flag = 0;
            a = a16;
            for (int k = 0; k < 3; k++)
                c[k] = c16[k];
            b2 = mag64(c[0]) * mag64(c[0]) + mag64(c[1]) * mag64(c[1])
                 + mag64(c[2]) * mag64(c[2]);
            // pole: zero vector with scalar exactly one in magnitude
            if (b2 == 0 && (a == ONE_Q || a == -ONE_Q))
            begin
                r.s = a > 0 ? SAT_HI[15:0] : SAT_LO[15:0];
                r.x = 0;
                r.y = 0;
                r.z = 0;
                r.flag = 1;
                return r;
            end
            // real part from the two logarithms
            up  = mag64(ONE_Q + a);
            sq  = up * up;
            plo = sq + b2;
            pc  = plo < sq;
            um  = mag64(ONE_Q - a);
            sq  = um * um;
            mlo = sq + b2;
            mc  = mlo < sq;
            d    = log2_q(pc, plo) - log2_q(mc, mlo);
            prod = mag64(d) * longint'(QLN2);
            mag  = (prod + (64'd1 << (55 - FRAC_BITS))) >> (56 - FRAC_BITS);
            re   = d < 0 ? -longint'(mag) : longint'(mag);
            r.s  = sat16(re, flag);
            // angle
            bq = root64(b2 << (2 * e));
            tq = ((mag64(a) * mag64(a)) >> 2) + (b2 >> 2);
            x0 = (64'sd1 <<< (2 * FRAC_BITS - 2)) - longint'(tq);
            if (FRAC_BITS - 1 - e >= 0)
                yv = bq << (FRAC_BITS - 1 - e);
            else
                yv = bq >> (e + 1 - FRAC_BITS);
            ang = angle_of(x0, yv);
            if (b2 == 0)
            begin
                // real axis: half angle on x
                h   = (ang + (64'sd1 <<< (30 - FRAC_BITS))) >>> (31 - FRAC_BITS);
                r.x = sat16(h, flag);
                r.y = 0;
                r.z = 0;
            end
            else
            begin
                for (int k = 0; k < 3; k++)
                begin
                    num = mag64(c[k]) * longint'(ang);
                    den = bq << (31 - e - FRAC_BITS);
                    q   = (num + den / 2) / den;
                    h   = c[k] < 0 ? -longint'(q) : longint'(q);
                    case (k)
                        0: r.x = sat16(h, flag);
                        1: r.y = sat16(h, flag);
                        default: r.z = sat16(h, flag);
                    endcase
                end
            end
            r.flag = flag;
            return r;
        endfunction

        function void note_command(logic signed [15:0] a16, logic signed [15:0] c16[3]);
            pending_atanh.push_back(atanh_predict(a16, c16));
        endfunction

        function void check_result(atanh_res_t got);
            atanh_res_t want;
            checked++;
            if (pending_atanh.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing pending: %h", got);
                return;
            end
            want = pending_atanh.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: want s=%h x=%h y=%h z=%h f=%b, got s=%h x=%h y=%h z=%h f=%b",
                             checked, want.s, want.x, want.y, want.z, want.flag,
                             got.s, got.x, got.y, got.z, got.flag);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] scalar_part;
    logic signed [15:0] vec_x;
    logic signed [15:0] vec_y;
    logic signed [15:0] vec_z;
    logic               done;
    logic signed [15:0] out_scalar;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic               pole_or_saturated;

    atanh_scoreboard sb;
    int              n_sent;
    bit              idle_on;

    quaternion_inverse_hyperbolic_tangent_unit u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .scalar_part       (scalar_part),
        .vec_x             (vec_x),
        .vec_y             (vec_y),
        .vec_z             (vec_z),
        .done              (done),
        .out_scalar        (out_scalar),
        .out_x             (out_x),
        .out_y             (out_y),
        .out_z             (out_z),
        .pole_or_saturated (pole_or_saturated)
    );

    initial
    begin
        clk = 0;
    end

    always #5 clk = ~clk;

    // Monitor: command transfers and result strobes at the rising edge
    always @(posedge clk)
    begin
        logic signed [15:0] cv[3];
        if (rst_n && start && !busy)
        begin
            cv[0] = vec_x;
            cv[1] = vec_y;
            cv[2] = vec_z;
            sb.note_command(scalar_part, cv);
        end
        if (rst_n && done)
            sb.check_result({out_scalar, out_x, out_y, out_z, pole_or_saturated});
    end

    // One command transfer, optionally preceded by an idle burst
    task automatic send_quat(logic [15:0] a, logic [15:0] x, logic [15:0] y, logic [15:0] z);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start       <= 1;
        scalar_part <= a;
        vec_x       <= x;
        vec_y       <= y;
        vec_z       <= z;
        do
            @(posedge clk);
        while (busy);
        n_sent++;
    endtask

    function automatic logic [15:0] near_val(int span);
        return 16'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    initial
    begin
        int kind;
        int wait_cnt;
        logic [15:0] a;
        sb          = new();
        n_sent      = 0;
        idle_on     = 1;
        rst_n       = 0;
        start       = 0;
        scalar_part = 0;
        vec_x       = 0;
        vec_y       = 0;
        vec_z       = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: poles, real axis both sides, extremes, pure vectors
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'h1000, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'hf000, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'h1000, 16'h0001, 16'h0000, 16'h0000);
        send_quat(16'hf000, 16'h0000, 16'hffff, 16'h0000);
        send_quat(16'h0800, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'hf800, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'h2000, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'he000, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'h7fff, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'h8000, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'h0fff, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'h1001, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h0000, 16'h7fff, 16'h0000, 16'h0000);
        send_quat(16'h0000, 16'h0000, 16'h8000, 16'h0000);
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h1000);
        send_quat(16'h0000, 16'h0001, 16'h0001, 16'h0001);
        send_quat(16'h1000, 16'h0000, 16'h0000, 16'h0001);
        send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h0001);
        send_quat(16'h0000, 16'hffff, 16'hffff, 16'hffff);
        send_quat(16'h0b50, 16'h0b50, 16'h0000, 16'h0000);

        // random: full range, small magnitudes, real axis, near the poles
        for (int i = 0; i < 1330; i++)
        begin
            if (i == 1130)
                idle_on = 0;
            kind = $urandom_range(0, 9);
            if (kind < 4)
            begin
                send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            end
            else if (kind < 7)
            begin
                send_quat(near_val(8192), near_val(4096), near_val(4096), near_val(4096));
            end
            else if (kind == 7)
            begin
                send_quat(16'($urandom), 16'h0000, 16'h0000, 16'h0000);
            end
            else
            begin
                a = $urandom_range(0, 1) ? 16'h1000 : 16'hf000;
                a = a + near_val(3);
                if ($urandom_range(0, 1))
                    send_quat(a, 16'h0000, 16'h0000, 16'h0000);
                else
                    send_quat(a, near_val(2), near_val(2), near_val(2));
            end
        end
        @(negedge clk);
        start <= 0;

        // drain the pipeline
        wait_cnt = 0;
        while (sb.pending_atanh.size() != 0 && wait_cnt < 20 * LATENCY)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (2 * LATENCY) @(posedge clk);

        $display("sent %0d quaternions (poles, real axis, extremes, random), checked %0d results",
                 n_sent, sb.checked);
        $display("mismatches %0d, still pending %0d", sb.mismatches, sb.pending_atanh.size());
        if (sb.mismatches == 0 && sb.pending_atanh.size() == 0)
            $display("quaternion_inverse_hyperbolic_tangent_unit: match");
        else
            $display("quaternion_inverse_hyperbolic_tangent_unit: mismatch");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("quaternion_inverse_hyperbolic_tangent_unit: mismatch");
        $finish;
    end

endmodule

>>> files.f
rtl/core/qath_pkg.sv
rtl/core/qath_log_cell.sv
rtl/core/qath_sqrt_cell.sv
rtl/core/qath_cordic_cell.sv
rtl/core/qath_div_cell.sv
rtl/core/quaternion_inverse_hyperbolic_tangent_unit.sv
test/quaternion_inverse_hyperbolic_tangent_unit_tb.sv
